>>> hdl/fbsf_pkg.sv
// fbsf_pkg: sizes, command codes, control and status structs and the
// fade arithmetic shared by the frame buffer shift/fade engine.
// no dependencies.
package fbsf_pkg;

	localparam int WIDTH  = 64;
	localparam int HEIGHT = 32;
	localparam int PLANES = 2;

	localparam int XW    = 6;
	localparam int YW    = 5;
	localparam int PW    = 1;
	localparam int AW    = PW + YW + XW;
	localparam int DEPTH = PLANES * HEIGHT * WIDTH;

	localparam int CMD_W  = 2;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int DX_W   = 8;
	localparam int DY_W   = 7;
	localparam int STEP_W = 9;
	localparam int THR_W  = 9;
	// wide enough for pixel coordinate minus any shift value
	localparam int OFS_W  = 10;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHIFT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FADE  = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic wr_pix;
		logic rd_pix;
		logic sweep_step;
		logic finish;
	} fbsf_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic sweep_last;
		logic out_free;
	} fbsf_stat_t;

	function automatic logic [CH_W-1:0] fade_chan(input logic [CH_W-1:0] v,
		input logic signed [STEP_W-1:0] step, input logic [THR_W-1:0] thr);
		logic signed [STEP_W:0] t;
		t = $signed({2'b00, v}) + $signed({step[STEP_W-1], step});
		if ({1'b0, v} < thr)
			return v;
		else if (t[STEP_W])
			return 8'h00;
		else if (t > $signed(10'd255))
			return 8'hFF;
		else
			return t[CH_W-1:0];
	endfunction

endpackage

>>> hdl/fbsf_ctrl.sv
// fbsf_ctrl: state machine that sequences the clear pass, pixel access
// and the plane sweeps. depends on fbsf_pkg.
module fbsf_ctrl
	import fbsf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] cmd,
	output logic             in_stall,
	input  fbsf_stat_t       stat,
	output fbsf_cmd_t        ctl
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RDOUT = 3'd4;
	localparam logic [2:0] ST_SWEEP = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       accept;

	assign in_stall = !(state_q == ST_IDLE && stat.out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (stat.clear_last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					case (cmd)
						CMD_WRITE: state_nx = ST_WRITE;
						CMD_READ:  state_nx = ST_READ;
						default:   state_nx = ST_SWEEP;
					endcase
				end
			end
			ST_WRITE: begin
				ctl.wr_pix = 1'b1;
				ctl.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			ST_READ: begin
				ctl.rd_pix = 1'b1;
				state_nx   = ST_RDOUT;
			end
			ST_RDOUT: begin
				ctl.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			ST_SWEEP: begin
				ctl.sweep_step = 1'b1;
				if (stat.sweep_last)
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last pixel write-back happens in this cycle
				ctl.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nx;
	end

endmodule

>>> hdl/fbsf_datapath.sv
// fbsf_datapath: frame store memory, command field registers, sweep counter,
// shift/fade write-back stage and the result register. depends on fbsf_pkg.
module fbsf_datapath
	import fbsf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  fbsf_cmd_t                ctl,
	output fbsf_stat_t               stat,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [PW-1:0]            plane,
	input  logic [XW-1:0]            pix_x,
	input  logic [YW-1:0]            pix_y,
	input  logic [CH_W-1:0]          wr_red,
	input  logic [CH_W-1:0]          wr_green,
	input  logic [CH_W-1:0]          wr_blue,
	input  logic signed [DX_W-1:0]   shift_x,
	input  logic signed [DY_W-1:0]   shift_y,
	input  logic signed [STEP_W-1:0] fade_amount,
	input  logic [THR_W-1:0]         fade_threshold,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CH_W-1:0]          rd_red,
	output logic [CH_W-1:0]          rd_green,
	output logic [CH_W-1:0]          rd_blue
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	logic [CMD_W-1:0]         cmd_q;
	logic [PW-1:0]            plane_q;
	logic [XW-1:0]            px_q;
	logic [YW-1:0]            py_q;
	logic [PIX_W-1:0]         wpix_q;
	logic signed [DX_W-1:0]   dx_q;
	logic signed [DY_W-1:0]   dy_q;
	logic signed [STEP_W-1:0] step_q;
	logic [THR_W-1:0]         thr_q;

	logic [AW-1:0] cnt_q;
	logic          plane_ok;
	logic          pix_ok;
	logic          rev_x;
	logic          rev_y;
	logic [XW-1:0] dst_x;
	logic [YW-1:0] dst_y;
	logic signed [OFS_W-1:0] src_x;
	logic signed [OFS_W-1:0] src_y;
	logic          src_ok;
	logic [AW-1:0] pix_addr;
	logic [AW-1:0] dst_addr;
	logic [AW-1:0] src_addr;

	logic          sw_wr_s1;
	logic [AW-1:0] sw_addr_s1;
	logic [PIX_W-1:0] sw_data;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [PIX_W-1:0] wdata;
	logic [AW-1:0]    raddr;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;

	assign plane_ok = 32'(plane_q) < PLANES;
	assign pix_ok   = plane_ok && 32'(px_q) < WIDTH && 32'(py_q) < HEIGHT;
	assign pix_addr = {plane_q, py_q, px_q};

	// walk in the direction that reads each source before it is overwritten
	assign rev_x = !dx_q[DX_W-1] && dx_q != '0;
	assign rev_y = !dy_q[DY_W-1] && dy_q != '0;
	assign dst_x = rev_x ? XW'(WIDTH - 1) - cnt_q[XW-1:0] : cnt_q[XW-1:0];
	assign dst_y = rev_y ? YW'(HEIGHT - 1) - cnt_q[XW+YW-1:XW] : cnt_q[XW+YW-1:XW];

	assign src_x = $signed({{(OFS_W-XW){1'b0}}, dst_x})
		- $signed({{(OFS_W-DX_W){dx_q[DX_W-1]}}, dx_q});
	assign src_y = $signed({{(OFS_W-YW){1'b0}}, dst_y})
		- $signed({{(OFS_W-DY_W){dy_q[DY_W-1]}}, dy_q});
	assign src_ok = !src_x[OFS_W-1] && $unsigned(src_x) < OFS_W'(WIDTH)
		&& !src_y[OFS_W-1] && $unsigned(src_y) < OFS_W'(HEIGHT);

	assign dst_addr = {plane_q, dst_y, dst_x};
	assign src_addr = {plane_q, src_y[YW-1:0], src_x[XW-1:0]};

	assign sw_data = (cmd_q == CMD_FADE) ?
		{fade_chan(rdata_q[PIX_W-1:2*CH_W], step_q, thr_q),
		 fade_chan(rdata_q[2*CH_W-1:CH_W], step_q, thr_q),
		 fade_chan(rdata_q[CH_W-1:0], step_q, thr_q)} : rdata_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = '0;
		if (ctl.clr_step) begin
			we = 1'b1;
		end else if (ctl.wr_pix) begin
			we    = pix_ok;
			waddr = pix_addr;
			wdata = wpix_q;
		end else if (sw_wr_s1) begin
			we    = 1'b1;
			waddr = sw_addr_s1;
			wdata = sw_data;
		end
	end

	assign raddr = ctl.rd_pix ? pix_addr : (cmd_q == CMD_SHIFT ? src_addr : dst_addr);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			plane_q <= plane;
			px_q    <= pix_x;
			py_q    <= pix_y;
			wpix_q  <= {wr_red, wr_green, wr_blue};
			dx_q    <= shift_x;
			dy_q    <= shift_y;
			step_q  <= fade_amount;
			thr_q   <= fade_threshold;
		end
		sw_addr_s1 <= dst_addr;
		if (ctl.finish)
			out_pix_q <= (cmd_q == CMD_READ && pix_ok) ? rdata_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sw_wr_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load)
				cnt_q <= '0;
			else if (ctl.clr_step || ctl.sweep_step)
				cnt_q <= cnt_q + 1'b1;
			sw_wr_s1 <= ctl.sweep_step && plane_ok && (cmd_q == CMD_FADE || src_ok);
			if (ctl.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.clear_last = &cnt_q;
	assign stat.sweep_last = &cnt_q[XW+YW-1:0];
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign rd_red    = out_pix_q[PIX_W-1:2*CH_W];
	assign rd_green  = out_pix_q[2*CH_W-1:CH_W];
	assign rd_blue   = out_pix_q[CH_W-1:0];

endmodule

>>> hdl/frame_buffer_shift_fade_engine_unit.sv
// frame buffer shift/fade engine, one item in flight at a time.
// a write passes the write state, a read the read and read-out states; shift and fade
// sweep the 2048-pixel plane with one read per pixel and a write-back of each fade pixel
// and each shift pixel whose source lies in the plane, then drain. the result register
// frees on take; no new item is accepted before then. after reset the 4096-entry
// frame store is cleared, one pixel a cycle, with in_stall high until the clear ends.
module frame_buffer_shift_fade_engine_unit
	import fbsf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [PW-1:0]            plane,
	input  logic [XW-1:0]            pix_x,
	input  logic [YW-1:0]            pix_y,
	input  logic [CH_W-1:0]          wr_red,
	input  logic [CH_W-1:0]          wr_green,
	input  logic [CH_W-1:0]          wr_blue,
	input  logic signed [DX_W-1:0]   shift_x,
	input  logic signed [DY_W-1:0]   shift_y,
	input  logic signed [STEP_W-1:0] fade_amount,
	input  logic [THR_W-1:0]         fade_threshold,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CH_W-1:0]          rd_red,
	output logic [CH_W-1:0]          rd_green,
	output logic [CH_W-1:0]          rd_blue
);

	fbsf_cmd_t  ctl;
	fbsf_stat_t stat;

	fbsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	fbsf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.cmd            (cmd),
		.plane          (plane),
		.pix_x          (pix_x),
		.pix_y          (pix_y),
		.wr_red         (wr_red),
		.wr_green       (wr_green),
		.wr_blue        (wr_blue),
		.shift_x        (shift_x),
		.shift_y        (shift_y),
		.fade_amount    (fade_amount),
		.fade_threshold (fade_threshold),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rd_red         (rd_red),
		.rd_green       (rd_green),
		.rd_blue        (rd_blue)
	);

endmodule
